>>> src/depth_jump_edge_filter_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the jump edge filter core
// Each macro expands to a labeled concurrent assertion in simulation and to
// nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef DEPTH_JUMP_EDGE_FILTER_CORE_ASSERT_SVH
`define DEPTH_JUMP_EDGE_FILTER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Checked only while out of reset.
`define DJE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked at every edge, reset included.
`define DJE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define DJE_ASSERT(lbl, prop, msg)
`define DJE_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

>>> src/dje_pkg.sv
// ----------------------------------------------------------------------------
// dje_pkg
// Shared types and constants of the jump edge filter core.
// ----------------------------------------------------------------------------
package dje_pkg;

  localparam int unsigned LIM_W   = 16;
  localparam int unsigned LW_W    = 11;
  localparam int unsigned OUT_W   = 10;
  localparam int unsigned IDX_W   = 2;
  localparam int unsigned Q_SHIFT = 15;
  localparam int unsigned L2_W    = 31;

  localparam logic [IDX_W-1:0] CFG_LINE_WIDTH = 2'd0;
  localparam logic [IDX_W-1:0] CFG_UPPER_COS  = 2'd1;
  localparam logic [IDX_W-1:0] CFG_LOWER_COS  = 2'd2;

  localparam logic [LW_W-1:0]         LINE_WIDTH_RST = 11'd640;
  localparam logic signed [LIM_W-1:0] UPPER_COS_RST  = -16'sd32270;
  localparam logic signed [LIM_W-1:0] LOWER_COS_RST  = 16'sd32270;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_READ,
    ST_MSQ_X,
    ST_MSQ_Y,
    ST_MSQ_Z,
    ST_LU,
    ST_LL,
    ST_NB,
    ST_DSQ_X,
    ST_DSQ_Y,
    ST_DSQ_Z,
    ST_P_X,
    ST_P_Y,
    ST_P_Z,
    ST_LHS,
    ST_TU,
    ST_RU,
    ST_TL,
    ST_RL,
    ST_DECIDE,
    ST_COMMIT
  } dje_state_e;

endpackage

>>> src/depth_jump_edge_filter_core.sv
// Flow: a border pixel passes only through read and commit; an interior pixel
//   runs a shift-add multiplier for each product, a load and then shift-add steps until the multiplier runs out.
//   A new item is taken only after the previous one is committed; the single shared
//   shift-add multiplier that computes all squares, dot products and limits sets the pace.
// Reset: asynchronous, active low; counters zero, window invalid, line stores
//   undefined until written, registers at their documented defaults.
// ----------------------------------------------------------------------------
// depth_jump_edge_filter_core
// Jump edge (veil point) filter over a 3x3 window of a raster ordered depth
// image, using exact squared cosine comparisons on a shared multiplier.
// ----------------------------------------------------------------------------
`include "depth_jump_edge_filter_core_assert.svh"

module depth_jump_edge_filter_core #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024,
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [COORD_BITS-1:0]        x_mm_i,
  input  logic signed [COORD_BITS-1:0]        y_mm_i,
  input  logic signed [COORD_BITS-1:0]        z_mm_i,
  input  logic                                point_valid_i,
  input  logic                                frame_start_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [dje_pkg::OUT_W-1:0]           center_row_o,
  output logic [dje_pkg::OUT_W-1:0]           center_col_o,
  output logic                                remove_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [dje_pkg::IDX_W-1:0]           cfg_index_i,
  input  logic [dje_pkg::LIM_W-1:0]           cfg_data_i
);

  // Widths of the intermediate values, derived from the coordinate width, and of the counters.
  localparam int unsigned CB    = COORD_BITS;
  localparam int unsigned MSQ_W = 2 * CB;
  localparam int unsigned DSQ_W = 2 * CB + 2;
  localparam int unsigned P_W   = 2 * CB + 2;
  localparam int unsigned Q_W   = 2 * CB + 16;
  localparam int unsigned LHS_W = 4 * CB + 32;
  localparam int unsigned T_W   = 2 * CB + 31;
  localparam int unsigned RHS_W = 4 * CB + 33;
  localparam int unsigned ACC_W = 4 * CB + 35;
  localparam int unsigned B_W   = 2 * CB + 16;
  localparam int unsigned CW    = $clog2(MAX_WIDTH);
  localparam int unsigned RW    = $clog2(MAX_HEIGHT);

  typedef struct packed {
    logic signed [CB-1:0] x;
    logic signed [CB-1:0] y;
    logic signed [CB-1:0] z;
    logic                 v;
  } point_t;

  // --------------------------------------------------------------------------
  // Configuration registers: write only while the core is idle; the core does not check.
  // --------------------------------------------------------------------------
  logic [dje_pkg::LW_W-1:0]         lw_q;
  logic signed [dje_pkg::LIM_W-1:0] lu_q;
  logic signed [dje_pkg::LIM_W-1:0] ll_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lw_q <= dje_pkg::LINE_WIDTH_RST;
      lu_q <= dje_pkg::UPPER_COS_RST;
      ll_q <= dje_pkg::LOWER_COS_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        dje_pkg::CFG_LINE_WIDTH: lw_q <= cfg_data_i[dje_pkg::LW_W-1:0];
        dje_pkg::CFG_UPPER_COS:  lu_q <= signed'(cfg_data_i);
        dje_pkg::CFG_LOWER_COS:  ll_q <= signed'(cfg_data_i);
        default: ;
      endcase
    end
  end

  // The programmed width is clamped to the range the line stores support.
  logic [31:0] lw32;
  logic [31:0] w32;
  assign lw32 = 32'(lw_q);
  assign w32  = (lw32 < 32'd3) ? 32'd3 :
                (lw32 > 32'(MAX_WIDTH)) ? 32'(MAX_WIDTH) : lw32;

  // --------------------------------------------------------------------------
  // Sequencer state and pixel context
  // --------------------------------------------------------------------------
  dje_pkg::dje_state_e state_q, state_d;

  logic [CW-1:0] col_q;
  logic [RW-1:0] row_q;
  logic [CW-1:0] col_cnt_q;
  logic [RW-1:0] row_cnt_q;
  logic          judged_q;
  logic [2:0]    k_q;
  logic          rm_q;
  point_t        cur_q;
  point_t        top_rd_q;
  point_t        mid_rd_q;
  point_t        win_q [6];

  logic accept;
  logic commit_go;
  assign in_ready_o = (state_q == dje_pkg::ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  // A judged pixel waits in commit until the output register is free.
  assign commit_go  = (state_q == dje_pkg::ST_COMMIT) &&
                      (!judged_q || !out_valid_q || out_ready_i);

  function automatic logic [RW-1:0] row_inc(input logic [RW-1:0] r);
    logic [RW-1:0] res;
    if (32'(r) == 32'(MAX_HEIGHT) - 32'd1) res = '0;
    else res = RW'(32'(r) + 32'd1);
    return res;
  endfunction

  // Column and row of the arriving item, after frame start and width shrink.
  logic [CW-1:0] col_start;
  logic [RW-1:0] row_start;
  logic [CW-1:0] col_eff;
  logic [RW-1:0] row_eff;
  always_comb begin
    col_start = frame_start_i ? '0 : col_cnt_q;
    row_start = frame_start_i ? '0 : row_cnt_q;
    if (32'(col_start) >= w32) begin
      col_eff = '0;
      row_eff = row_inc(row_start);
    end else begin
      col_eff = col_start;
      row_eff = row_start;
    end
  end

  // Line stores: registered read on accept, write on commit.
  point_t pp_mem [MAX_WIDTH];
  point_t p_mem  [MAX_WIDTH];
  always_ff @(posedge clk_i) begin
    if (accept) begin
      top_rd_q <= pp_mem[col_eff];
      mid_rd_q <= p_mem[col_eff];
    end
    if (commit_go) begin
      pp_mem[col_q] <= mid_rd_q;
      p_mem[col_q]  <= cur_q;
    end
  end

  // --------------------------------------------------------------------------
  // Centre, neighbour and their derived magnitudes
  // --------------------------------------------------------------------------
  point_t cen;
  point_t nb;
  assign cen = win_q[1];

  always_comb begin
    case (k_q)
      3'd0:    nb = win_q[0];
      3'd1:    nb = win_q[2];
      3'd2:    nb = win_q[3];
      3'd3:    nb = win_q[4];
      3'd4:    nb = win_q[5];
      3'd5:    nb = top_rd_q;
      3'd6:    nb = mid_rd_q;
      default: nb = cur_q;
    endcase
  end

  logic signed [CB:0] dx, dy, dz;
  assign dx = (CB+1)'(cen.x) - (CB+1)'(nb.x);
  assign dy = (CB+1)'(cen.y) - (CB+1)'(nb.y);
  assign dz = (CB+1)'(cen.z) - (CB+1)'(nb.z);

  logic [CB-1:0] cx_mag, cy_mag, cz_mag;
  logic [CB:0]   dx_mag, dy_mag, dz_mag;
  assign cx_mag = cen.x[CB-1] ? CB'(-cen.x) : CB'(cen.x);
  assign cy_mag = cen.y[CB-1] ? CB'(-cen.y) : CB'(cen.y);
  assign cz_mag = cen.z[CB-1] ? CB'(-cen.z) : CB'(cen.z);
  assign dx_mag = dx[CB] ? (CB+1)'(-dx) : (CB+1)'(dx);
  assign dy_mag = dy[CB] ? (CB+1)'(-dy) : (CB+1)'(dy);
  assign dz_mag = dz[CB] ? (CB+1)'(-dz) : (CB+1)'(dz);

  logic [dje_pkg::LIM_W-1:0] lu_mag, ll_mag;
  assign lu_mag = lu_q[dje_pkg::LIM_W-1] ? dje_pkg::LIM_W'(-lu_q) : dje_pkg::LIM_W'(lu_q);
  assign ll_mag = ll_q[dje_pkg::LIM_W-1] ? dje_pkg::LIM_W'(-ll_q) : dje_pkg::LIM_W'(ll_q);

  // Products held between steps.
  logic [MSQ_W-1:0]        msq_q;
  logic [dje_pkg::L2_W-1:0] lu2_q, ll2_q;
  logic [DSQ_W-1:0]        dsq_q;
  logic signed [P_W-1:0]   p_q;
  logic [LHS_W-1:0]        lhs_q;
  logic [T_W-1:0]          tu_q, tl_q;
  logic [RHS_W-1:0]        rhsu_q, rhsl_q;

  logic [P_W-1:0] p_mag;
  logic [Q_W-1:0] q_val;
  assign p_mag = p_q[P_W-1] ? P_W'(-p_q) : P_W'(p_q);
  assign q_val = Q_W'({p_mag, {dje_pkg::Q_SHIFT{1'b0}}});

  // --------------------------------------------------------------------------
  // Shared shift-add multiplier. Each step adds or subtracts the shifted
  // multiplicand when the low multiplier bit is set; done when it runs out.
  // --------------------------------------------------------------------------
  logic                    run_q;
  logic [ACC_W-1:0]        a_q;
  logic [B_W-1:0]          b_q;
  logic                    neg_q;
  logic signed [ACC_W-1:0] acc_q;
  logic                    finish;
  logic                    is_op;
  assign finish = run_q && (b_q == '0);

  logic [ACC_W-1:0] op_a;
  logic [B_W-1:0]   op_b;
  logic             op_neg;
  logic             op_clr;

  // Operand selection for each multiply step of the sequencer.
  always_comb begin
    op_a   = '0;
    op_b   = '0;
    op_neg = 1'b0;
    op_clr = 1'b0;
    is_op  = 1'b1;
    unique case (state_q)
      dje_pkg::ST_MSQ_X: begin
        op_a = ACC_W'(cx_mag); op_b = B_W'(cx_mag); op_clr = 1'b1;
      end
      dje_pkg::ST_MSQ_Y: begin op_a = ACC_W'(cy_mag); op_b = B_W'(cy_mag); end
      dje_pkg::ST_MSQ_Z: begin op_a = ACC_W'(cz_mag); op_b = B_W'(cz_mag); end
      dje_pkg::ST_LU: begin
        op_a = ACC_W'(lu_mag); op_b = B_W'(lu_mag); op_clr = 1'b1;
      end
      dje_pkg::ST_LL: begin
        op_a = ACC_W'(ll_mag); op_b = B_W'(ll_mag); op_clr = 1'b1;
      end
      dje_pkg::ST_DSQ_X: begin
        op_a = ACC_W'(dx_mag); op_b = B_W'(dx_mag); op_clr = 1'b1;
      end
      dje_pkg::ST_DSQ_Y: begin op_a = ACC_W'(dy_mag); op_b = B_W'(dy_mag); end
      dje_pkg::ST_DSQ_Z: begin op_a = ACC_W'(dz_mag); op_b = B_W'(dz_mag); end
      dje_pkg::ST_P_X: begin
        op_a = ACC_W'(cx_mag); op_b = B_W'(dx_mag);
        op_neg = cen.x[CB-1] ^ dx[CB]; op_clr = 1'b1;
      end
      dje_pkg::ST_P_Y: begin
        op_a = ACC_W'(cy_mag); op_b = B_W'(dy_mag); op_neg = cen.y[CB-1] ^ dy[CB];
      end
      dje_pkg::ST_P_Z: begin
        op_a = ACC_W'(cz_mag); op_b = B_W'(dz_mag); op_neg = cen.z[CB-1] ^ dz[CB];
      end
      dje_pkg::ST_LHS: begin
        op_a = ACC_W'(q_val); op_b = B_W'(q_val); op_clr = 1'b1;
      end
      dje_pkg::ST_TU: begin
        op_a = ACC_W'(msq_q); op_b = B_W'(lu2_q); op_clr = 1'b1;
      end
      dje_pkg::ST_RU: begin
        op_a = ACC_W'(tu_q); op_b = B_W'(dsq_q); op_clr = 1'b1;
      end
      dje_pkg::ST_TL: begin
        op_a = ACC_W'(msq_q); op_b = B_W'(ll2_q); op_clr = 1'b1;
      end
      dje_pkg::ST_RL: begin
        op_a = ACC_W'(tl_q); op_b = B_W'(dsq_q); op_clr = 1'b1;
      end
      default: is_op = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
    end else if (is_op) begin
      run_q <= !finish;
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_op && !run_q) begin
      a_q   <= op_a;
      b_q   <= op_b;
      neg_q <= op_neg;
      if (op_clr) acc_q <= '0;
    end else if (run_q && (b_q != '0)) begin
      if (b_q[0]) acc_q <= neg_q ? acc_q - signed'(a_q) : acc_q + signed'(a_q);
      a_q <= a_q << 1;
      b_q <= b_q >> 1;
    end
  end

  // --------------------------------------------------------------------------
  // Verdict for the current neighbour, with the sign cases kept apart from
  // the squared magnitude comparison.
  // --------------------------------------------------------------------------
  logic             pneg;
  logic [RHS_W-1:0] lhs_ext;
  logic             below_upper, above_lower, rm_now;
  assign pneg    = p_q[P_W-1];
  assign lhs_ext = RHS_W'(lhs_q);

  always_comb begin
    if (pneg && !lu_q[dje_pkg::LIM_W-1])      below_upper = 1'b1;
    else if (!pneg && lu_q[dje_pkg::LIM_W-1]) below_upper = 1'b0;
    else if (!pneg)                           below_upper = lhs_ext < rhsu_q;
    else                                      below_upper = lhs_ext > rhsu_q;
    if (!pneg && ll_q[dje_pkg::LIM_W-1])      above_lower = 1'b1;
    else if (pneg && !ll_q[dje_pkg::LIM_W-1]) above_lower = 1'b0;
    else if (!pneg)                           above_lower = lhs_ext > rhsl_q;
    else                                      above_lower = lhs_ext < rhsl_q;
    rm_now = below_upper || above_lower;
  end

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  logic last_nb;
  assign last_nb = (k_q == 3'd7);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dje_pkg::ST_IDLE:   if (accept) state_d = dje_pkg::ST_READ;
      dje_pkg::ST_READ:   state_d = (judged_q && cen.v) ? dje_pkg::ST_MSQ_X
                                                        : dje_pkg::ST_COMMIT;
      dje_pkg::ST_MSQ_X:  if (finish) state_d = dje_pkg::ST_MSQ_Y;
      dje_pkg::ST_MSQ_Y:  if (finish) state_d = dje_pkg::ST_MSQ_Z;
      dje_pkg::ST_MSQ_Z:  if (finish) state_d = (acc_q == '0) ? dje_pkg::ST_COMMIT
                                                               : dje_pkg::ST_LU;
      dje_pkg::ST_LU:     if (finish) state_d = dje_pkg::ST_LL;
      dje_pkg::ST_LL:     if (finish) state_d = dje_pkg::ST_NB;
      dje_pkg::ST_NB: begin
        if (nb.v) state_d = dje_pkg::ST_DSQ_X;
        else if (last_nb) state_d = dje_pkg::ST_COMMIT;
      end
      dje_pkg::ST_DSQ_X:  if (finish) state_d = dje_pkg::ST_DSQ_Y;
      dje_pkg::ST_DSQ_Y:  if (finish) state_d = dje_pkg::ST_DSQ_Z;
      dje_pkg::ST_DSQ_Z: begin
        if (finish) begin
          if (acc_q != '0) state_d = dje_pkg::ST_P_X;
          else state_d = last_nb ? dje_pkg::ST_COMMIT : dje_pkg::ST_NB;
        end
      end
      dje_pkg::ST_P_X:    if (finish) state_d = dje_pkg::ST_P_Y;
      dje_pkg::ST_P_Y:    if (finish) state_d = dje_pkg::ST_P_Z;
      dje_pkg::ST_P_Z:    if (finish) state_d = dje_pkg::ST_LHS;
      dje_pkg::ST_LHS:    if (finish) state_d = dje_pkg::ST_TU;
      dje_pkg::ST_TU:     if (finish) state_d = dje_pkg::ST_RU;
      dje_pkg::ST_RU:     if (finish) state_d = dje_pkg::ST_TL;
      dje_pkg::ST_TL:     if (finish) state_d = dje_pkg::ST_RL;
      dje_pkg::ST_RL:     if (finish) state_d = dje_pkg::ST_DECIDE;
      dje_pkg::ST_DECIDE: state_d = (rm_now || last_nb) ? dje_pkg::ST_COMMIT
                                                        : dje_pkg::ST_NB;
      dje_pkg::ST_COMMIT: if (commit_go) state_d = dje_pkg::ST_IDLE;
      default:            state_d = dje_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= dje_pkg::ST_IDLE;
    else         state_q <= state_d;
  end

  // Results of finished multiplies are latched into their holding registers.
  always_ff @(posedge clk_i) begin
    if (finish) begin
      case (state_q)
        dje_pkg::ST_MSQ_Z: msq_q  <= acc_q[MSQ_W-1:0];
        dje_pkg::ST_LU:    lu2_q  <= acc_q[dje_pkg::L2_W-1:0];
        dje_pkg::ST_LL:    ll2_q  <= acc_q[dje_pkg::L2_W-1:0];
        dje_pkg::ST_DSQ_Z: dsq_q  <= acc_q[DSQ_W-1:0];
        dje_pkg::ST_P_Z:   p_q    <= signed'(acc_q[P_W-1:0]);
        dje_pkg::ST_LHS:   lhs_q  <= acc_q[LHS_W-1:0];
        dje_pkg::ST_TU:    tu_q   <= acc_q[T_W-1:0];
        dje_pkg::ST_RU:    rhsu_q <= acc_q[RHS_W-1:0];
        dje_pkg::ST_TL:    tl_q   <= acc_q[T_W-1:0];
        dje_pkg::ST_RL:    rhsl_q <= acc_q[RHS_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pixel context, neighbour index, verdict and counters
  // --------------------------------------------------------------------------
  logic [CW:0] col_nxt;
  assign col_nxt = (CW+1)'(col_q) + (CW+1)'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_cnt_q <= '0;
      row_cnt_q <= '0;
      col_q     <= '0;
      row_q     <= '0;
      judged_q  <= 1'b0;
      k_q       <= '0;
      rm_q      <= 1'b0;
      for (int i = 0; i < 6; i++) win_q[i] <= '0;
    end else begin
      if (accept) begin
        col_q    <= col_eff;
        row_q    <= row_eff;
        judged_q <= (32'(row_eff) >= 32'd2) && (32'(col_eff) >= 32'd2);
        k_q      <= '0;
        rm_q     <= 1'b0;
      end
      if ((state_q == dje_pkg::ST_NB && !nb.v && !last_nb) ||
          (state_q == dje_pkg::ST_DSQ_Z && finish && acc_q == '0 && !last_nb) ||
          (state_q == dje_pkg::ST_DECIDE && !rm_now && !last_nb)) begin
        k_q <= k_q + 3'd1;
      end
      if (state_q == dje_pkg::ST_DECIDE) rm_q <= rm_now;
      if (commit_go) begin
        win_q[3] <= win_q[0];
        win_q[4] <= win_q[1];
        win_q[5] <= win_q[2];
        win_q[0] <= top_rd_q;
        win_q[1] <= mid_rd_q;
        win_q[2] <= cur_q;
        if (32'(col_nxt) >= w32) begin
          col_cnt_q <= '0;
          row_cnt_q <= row_inc(row_q);
        end else begin
          col_cnt_q <= col_nxt[CW-1:0];
          row_cnt_q <= row_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cur_q.x <= x_mm_i;
      cur_q.y <= y_mm_i;
      cur_q.z <= z_mm_i;
      cur_q.v <= point_valid_i;
    end
  end

  // --------------------------------------------------------------------------
  // Output register: the next item may be accepted while a result waits.
  // --------------------------------------------------------------------------
  logic                      out_valid_q;
  logic [dje_pkg::OUT_W-1:0] out_row_q;
  logic [dje_pkg::OUT_W-1:0] out_col_q;
  logic                      out_rm_q;
  logic [31:0]               row_m1;
  logic [31:0]               col_m1;
  assign row_m1 = 32'(row_q) - 32'd1;
  assign col_m1 = 32'(col_q) - 32'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit_go && judged_q) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit_go && judged_q) begin
      out_row_q <= row_m1[dje_pkg::OUT_W-1:0];
      out_col_q <= col_m1[dje_pkg::OUT_W-1:0];
      out_rm_q  <= rm_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign center_row_o = out_row_q;
  assign center_col_o = out_col_q;
  assign remove_o     = out_rm_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `DJE_ASSERT(a_accept_reads, accept |=> state_q == dje_pkg::ST_READ, "accept did not start a read")
  `DJE_ASSERT(a_run_in_op, run_q |-> is_op, "multiplier running outside a multiply step")
  `DJE_ASSERT(a_commit_out, commit_go && judged_q |=> out_valid_q, "judged pixel gave no result")
  `DJE_ASSERT(a_rm_decide, $rose(rm_q) |-> $past(state_q) == dje_pkg::ST_DECIDE, "verdict set outside decide")
  `DJE_ASSERT_ALWAYS(a_reset_out, !rst_ni |=> !out_valid_q, "result valid right after reset")

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Jump edge filter core testbench
// Streams depth frames through the core with random stalls on both sides,
// predicts every interior verdict with an independent behavioral model that
// uses exact wide-integer cosine comparisons, and checks each verdict in order.
// ----------------------------------------------------------------------------
module testbench;
  import dje_pkg::*;

  localparam int unsigned MAXW = 1024;
  localparam int unsigned MAXH = 1024;

  // Point generation styles for the frame builder.
  localparam int PT_SMOOTH = 0;  // gently sloped surface, a few holes
  localparam int PT_EDGE   = 1;  // surface with depth jumps
  localparam int PT_NOISE  = 2;  // full range coordinates and validity

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    bit                 v;
  } point_t;

  typedef struct {
    logic [OUT_W-1:0] row;
    logic [OUT_W-1:0] col;
    bit               drop;
  } verdict_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [15:0] x_mm_i = '0;
  logic signed [15:0] y_mm_i = '0;
  logic signed [15:0] z_mm_i = '0;
  logic point_valid_i = 1'b0;
  logic frame_start_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [OUT_W-1:0] center_row_o;
  logic [OUT_W-1:0] center_col_o;
  logic remove_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [IDX_W-1:0] cfg_index_i = CFG_LINE_WIDTH;
  logic [LIM_W-1:0] cfg_data_i = '0;

  always #1 clk_i = ~clk_i;

  depth_jump_edge_filter_core dut (.*);

  // Shadow of the core state used to predict verdicts.
  point_t      line_above[MAXW];
  point_t      line_two_above[MAXW];
  point_t      win[6];
  int unsigned col_cnt;
  int unsigned row_cnt;
  logic [LW_W-1:0]          width_reg = LINE_WIDTH_RST;
  logic signed [LIM_W-1:0]  upper_lim = UPPER_COS_RST;
  logic signed [LIM_W-1:0]  lower_lim = LOWER_COS_RST;

  verdict_t pending_verdicts[$];
  int       errors = 0;
  int       items_sent = 0;
  int       verdicts_seen = 0;
  int       removals_seen = 0;
  bit       quiet = 1'b0;  // no idling on either side when set
  int       sink_stall = 0;

  // Sign of (|p| * 2^15)^2 - L^2 * |m|^2 * |d|^2, all in 128-bit integers.
  function automatic int cos_square_cmp(logic [127:0] lhs, int lim,
                                        logic [127:0] msq, logic [127:0] dsq);
    logic [127:0] la;
    logic [127:0] rhs;
    la  = (lim < 0) ? -lim : lim;
    rhs = la * la * msq * dsq;
    if (lhs > rhs) return 1;
    if (lhs < rhs) return -1;
    return 0;
  endfunction

  // True when the angle between the viewing ray of c and the vector c - q
  // falls outside the configured window.
  function automatic bit angle_out_of_range(point_t c, point_t q);
    longint dx, dy, dz, p, mq, dq;
    logic [127:0] pabs, lhs;
    bit pneg, below_upper, above_lower;
    int cu, cl;
    if (!c.v || !q.v) return 1'b0;
    dx = longint'(c.x) - longint'(q.x);
    dy = longint'(c.y) - longint'(q.y);
    dz = longint'(c.z) - longint'(q.z);
    mq = longint'(c.x) * c.x + longint'(c.y) * c.y + longint'(c.z) * c.z;
    dq = dx * dx + dy * dy + dz * dz;
    // A degenerate ray or a coincident neighbour never removes.
    if (mq == 0 || dq == 0) return 1'b0;
    p    = longint'(c.x) * dx + longint'(c.y) * dy + longint'(c.z) * dz;
    pneg = p < 0;
    pabs = pneg ? -p : p;
    lhs  = (pabs << 15) * (pabs << 15);
    cu = cos_square_cmp(lhs, int'(upper_lim), mq, dq);
    cl = cos_square_cmp(lhs, int'(lower_lim), mq, dq);
    if (pneg && upper_lim >= 0)       below_upper = 1'b1;
    else if (!pneg && upper_lim < 0)  below_upper = 1'b0;
    else if (!pneg)                   below_upper = cu < 0;
    else                              below_upper = cu > 0;
    if (!pneg && lower_lim < 0)       above_lower = 1'b1;
    else if (pneg && lower_lim >= 0)  above_lower = 1'b0;
    else if (!pneg)                   above_lower = cl > 0;
    else                              above_lower = cl < 0;
    return below_upper || above_lower;
  endfunction

  // Advances the shadow state by one pixel and queues the verdict it causes.
  function automatic void predict_pixel(point_t cur, bit fs);
    int unsigned w, col;
    point_t top, mid;
    point_t nb[8];
    verdict_t vd;
    w = width_reg;
    if (w < 3) w = 3;
    if (w > MAXW) w = MAXW;
    if (fs) begin
      col_cnt = 0;
      row_cnt = 0;
    end
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt = (row_cnt + 1) % MAXH;
    end
    col = col_cnt;
    top = line_two_above[col];
    mid = line_above[col];
    if (row_cnt >= 2 && col >= 2) begin
      nb = '{win[0], win[2], win[3], win[4], win[5], top, mid, cur};
      vd.row  = OUT_W'(row_cnt - 1);
      vd.col  = OUT_W'(col - 1);
      vd.drop = 1'b0;
      foreach (nb[k]) if (!vd.drop) vd.drop = angle_out_of_range(win[1], nb[k]);
      pending_verdicts.push_back(vd);
    end
    win[3] = win[0];
    win[4] = win[1];
    win[5] = win[2];
    win[0] = top;
    win[1] = mid;
    win[2] = cur;
    line_two_above[col] = mid;
    line_above[col] = cur;
    col_cnt = col + 1;
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt = (row_cnt + 1) % MAXH;
    end
  endfunction

  // Sends one pixel. Valid stays high after acceptance so that back to back
  // items need only one assignment per falling edge.
  task automatic send_pixel(point_t pt, bit fs);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      @(negedge clk_i) in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i) begin
      in_valid_i    <= 1'b1;
      x_mm_i        <= pt.x;
      y_mm_i        <= pt.y;
      z_mm_i        <= pt.z;
      point_valid_i <= pt.v;
      frame_start_i <= fs;
    end
    do @(posedge clk_i); while (!in_ready_o);
    predict_pixel(pt, fs);
    items_sent++;
  endtask

  // Waits until every verdict has arrived and the core has had time to
  // finish a trailing border pixel.
  task automatic drain();
    @(negedge clk_i) in_valid_i <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [LIM_W-1:0] data);
    drain();
    @(negedge clk_i) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx;
      cfg_data_i  <= data;
    end
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_LINE_WIDTH: width_reg = data[LW_W-1:0];
      CFG_UPPER_COS:  upper_lim = data;
      CFG_LOWER_COS:  lower_lim = data;
      default: ;
    endcase
    @(negedge clk_i) cfg_valid_i <= 1'b0;
  endtask

  task automatic set_width(int unsigned w);
    logic [4:0] junk;
    junk = $urandom;  // upper data bits are ignored by the core
    write_reg(CFG_LINE_WIDTH, {junk, LW_W'(w)});
  endtask

  function automatic point_t make_point(int r, int c, int style);
    point_t pt;
    pt.x = 16'(c * 12 - 60 + $urandom_range(0, 3));
    pt.y = 16'(r * 12 - 40 + $urandom_range(0, 3));
    pt.z = 16'(1500 + $urandom_range(0, 8));
    pt.v = $urandom_range(0, 15) != 0;
    if (style == PT_EDGE && $urandom_range(0, 3) == 0)
      pt.z = pt.z + 16'($urandom_range(200, 4000));
    if (style == PT_NOISE) begin
      pt.x = $urandom;
      pt.y = $urandom;
      pt.z = $urandom;
      pt.v = $urandom_range(0, 1);
    end
    return pt;
  endfunction

  task automatic send_frame(int w, int h, int style);
    for (int r = 0; r < h; r++)
      for (int c = 0; c < w; c++)
        send_pixel(make_point(r, c, style), r == 0 && c == 0);
  endtask

  // Result checker: each accepted verdict is compared with the oldest one
  // predicted.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected verdict row %0d col %0d remove %0b",
                 $time, center_row_o, center_col_o, remove_o);
        errors++;
      end else begin
        verdict_t vd;
        vd = pending_verdicts.pop_front();
        if (center_row_o !== vd.row) begin
          $display("%0t: center_row expected %0d actual %0d", $time, vd.row, center_row_o);
          errors++;
        end
        if (center_col_o !== vd.col) begin
          $display("%0t: center_col expected %0d actual %0d", $time, vd.col, center_col_o);
          errors++;
        end
        if (remove_o !== vd.drop) begin
          $display("%0t: remove at (%0d,%0d) expected %0b actual %0b",
                   $time, vd.row, vd.col, vd.drop, remove_o);
          errors++;
        end
      end
      verdicts_seen++;
      if (remove_o === 1'b1) removals_seen++;
    end
  end

  // Receiver stalls in random bursts unless quiet is set.
  always @(negedge clk_i) begin
    if (sink_stall > 0) begin
      sink_stall--;
      out_ready_i <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      sink_stall = $urandom_range(0, 4);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Reset limits, extreme coordinates, missing points, a zero ray and a
  // neighbour that coincides with the centre.
  task automatic test_directed_extremes();
    point_t pts[20];
    set_width(5);
    for (int i = 0; i < 20; i++) pts[i] = make_point(i / 5, i % 5, PT_SMOOTH);
    pts[0] = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b1};
    pts[1] = '{16'sh8000, 16'sh8000, 16'sh8000, 1'b1};
    pts[2] = '{16'sh8000, 16'sh7FFF, 16'sh0000, 1'b1};
    pts[6] = '{16'sh0000, 16'sh0000, 16'sh0000, 1'b1};  // zero ray as centre
    pts[7] = pts[8];                                     // coincident neighbour
    pts[11] = '{16'sh7FFF, 16'sh8000, 16'sh7FFF, 1'b1};
    pts[12].v = 1'b0;                                    // missing centre
    pts[13] = '{16'sh8000, 16'sh8000, 16'sh7FFF, 1'b1};
    pts[17].v = 1'b0;                                    // missing neighbour
    for (int i = 0; i < 20; i++) send_pixel(pts[i], i == 0);
    drain();  // hold the source until every verdict is in
  endtask

  // Extreme and sign-flipped cosine limits.
  task automatic test_cos_limits();
    logic [LIM_W-1:0] lims[4][2];
    lims = '{'{16'h8000, 16'h7FFF}, '{16'h7FFF, 16'h8000},
             '{16'h0000, 16'h0000}, '{16'hC000, 16'h4000}};
    for (int i = 0; i < 4; i++) begin
      write_reg(CFG_UPPER_COS, lims[i][0]);
      write_reg(CFG_LOWER_COS, lims[i][1]);
      send_frame(4, 3, i[0] ? PT_NOISE : PT_EDGE);
    end
    write_reg(CFG_UPPER_COS, UPPER_COS_RST);
    write_reg(CFG_LOWER_COS, LOWER_COS_RST);
  endtask

  // Widths below 3 and above the line store size saturate.
  task automatic test_width_saturation();
    set_width(0);
    send_frame(3, 3, PT_EDGE);
    set_width(2);
    send_frame(3, 4, PT_SMOOTH);
    set_width(2047);
    send_frame(20, 2, PT_EDGE);  // no verdicts before row two
    set_width(1024);
    send_frame(30, 1, PT_SMOOTH);
  endtask

  // Width shrinks in the middle of a row, forcing the column to wrap.
  task automatic test_column_overrun();
    set_width(8);
    send_frame(8, 2, PT_EDGE);
    for (int c = 0; c < 6; c++) send_pixel(make_point(2, c, PT_EDGE), 1'b0);
    set_width(4);
    for (int i = 0; i < 12; i++) send_pixel(make_point(3, i, PT_EDGE), 1'b0);
  endtask

  // More rows than the row counter holds without a new frame flag.
  task automatic test_row_wrap();
    set_width(3);
    send_frame(3, MAXH + 3, PT_EDGE);
  endtask

  // Random frames with random content, widths and limits; a stray frame
  // start now and then breaks a frame in the middle.
  task automatic test_random_frames();
    int budget, w, h, style, last_part;
    budget = 1450;
    last_part = 220;
    while (budget > 0) begin
      quiet = budget < last_part;
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(3, 8);
      h = $urandom_range(3, 6);
      style = ($urandom_range(0, 5) == 0) ? PT_NOISE : $urandom_range(PT_SMOOTH, PT_EDGE);
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 2))
          0: write_reg(CFG_UPPER_COS, 16'($urandom));
          1: write_reg(CFG_LOWER_COS, 16'($urandom));
          default: begin
            write_reg(CFG_UPPER_COS, 16'(-32768 + $urandom_range(0, 3000)));
            write_reg(CFG_LOWER_COS, 16'(32767 - $urandom_range(0, 6000)));
          end
        endcase
      end
      set_width(w);
      for (int r = 0; r < h; r++)
        for (int c = 0; c < w; c++)
          send_pixel(make_point(r, c, style),
                     (r == 0 && c == 0) || $urandom_range(0, 299) == 0);
      budget -= w * h;
    end
  endtask

  initial begin
    foreach (line_above[i]) begin
      line_above[i] = '{0, 0, 0, 1'b0};
      line_two_above[i] = '{0, 0, 0, 1'b0};
    end
    foreach (win[i]) win[i] = '{0, 0, 0, 1'b0};
    col_cnt = 0;
    row_cnt = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    test_directed_extremes();
    test_cos_limits();
    test_width_saturation();
    test_column_overrun();
    test_row_wrap();
    test_random_frames();

    drain();
    repeat (50) @(posedge clk_i);
    $display("Sent %0d pixels; %0d verdicts checked, %0d of them removals.",
             items_sent, verdicts_seen, removals_seen);
    $display("Covered extreme limits, width saturation, column wrap and row wrap.");
    if (errors == 0 && pending_verdicts.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      if (pending_verdicts.size() != 0)
        $display("%0t: %0d verdicts never arrived", $time, pending_verdicts.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("Timeout with %0d verdicts outstanding", pending_verdicts.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
